// ----- sv/hnms_pkg.sv -----
// ----------------------------------------------------------------------------
// hnms_pkg: shared types and constants for the heatmap window-max NMS block
// Score type, register index codes, register reset values and default sizes.
// ----------------------------------------------------------------------------
package hnms_pkg;

  localparam int SCORE_W      = 16;
  localparam int COORD_W      = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FRAME_DIM_W  = 11;
  localparam int RADIUS_CFG_W = 2;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 2;
  localparam int MAX_HEIGHT     = 1024;

  typedef logic [SCORE_W-1:0] score_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_WINDOW_RADIUS   = 2'd2,
    CFG_SCORE_THRESHOLD = 2'd3
  } cfg_index_e;

  localparam logic [FRAME_DIM_W-1:0]  RST_FRAME_WIDTH   = 11'd640;
  localparam logic [FRAME_DIM_W-1:0]  RST_FRAME_HEIGHT  = 11'd352;
  localparam logic [RADIUS_CFG_W-1:0] RST_WINDOW_RADIUS = 2'd2;
  localparam score_t                  RST_THRESHOLD     = 16'd3277;

endpackage

// ----- sv/hnms_line_buf.sv -----
// ----------------------------------------------------------------------------
// hnms_line_buf: column history memory
// One word per column holds the scores of the previous rows of that column.
// Registered read with forwarding of a write to the same address.
// ----------------------------------------------------------------------------
module hnms_line_buf #(
  parameter int Depth = 1026,
  parameter int Rows  = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(Depth)-1:0]              rd_addr_i,
  output hnms_pkg::score_t [Rows-1:0]           rd_data_o,
  input  logic                                  wr_en_i,
  input  logic [$clog2(Depth)-1:0]              wr_addr_i,
  input  hnms_pkg::score_t [Rows-1:0]           wr_data_i
);
  import hnms_pkg::*;

  score_t [Rows-1:0] mem [Depth];
  score_t [Rows-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/hnms_cell.sv -----
// ----------------------------------------------------------------------------
// hnms_cell: one window column
// Holds a column of scores, hands it to the next cell on each shift and
// flags any in-image score above the window center.
// ----------------------------------------------------------------------------
module hnms_cell #(
  parameter int Rows = 5
) (
  input  logic                        clk_i,
  input  logic                        shift_i,
  input  hnms_pkg::score_t [Rows-1:0] col_i,
  output hnms_pkg::score_t [Rows-1:0] col_o,
  input  logic                        col_ok_i,
  input  logic [Rows-1:0]             row_ok_i,
  input  hnms_pkg::score_t            center_i,
  output logic                        gt_o
);
  import hnms_pkg::*;

  score_t [Rows-1:0] col_q;
  logic   [Rows-1:0] gt_row;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    for (int k = 0; k < Rows; k++) begin
      gt_row[k] = row_ok_i[k] && (col_q[k] > center_i);
    end
  end

  assign col_o = col_q;
  assign gt_o  = col_ok_i && (|gt_row);

endmodule

// ----- sv/heatmap_window_max_nms.sv -----
// ----------------------------------------------------------------------------
// heatmap_window_max_nms: streaming square-window non-maximum suppression
// Raster heatmap in, one keypoint decision per item out, row-major order.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled and gives one result per item,
// registered in stage 1, stage 2 and the output register; a stalled output
// holds the whole pipeline. The frame arrives padded to (height+radius) rows
// by (width+radius) columns; each item decides the pixel radius rows and
// columns back. Previous rows live in one RAM of MaxWidth+MaxRadius words by
// 2*MaxRadius scores, read and written once per item, and the window is a row
// of 2*MaxRadius+1 column cells. Out-of-image neighbors are masked by
// position, so the RAM needs no clearing after reset. Geometry and threshold
// are sampled on the first item of each frame.
module heatmap_window_max_nms #(
  parameter int MaxWidth  = hnms_pkg::MAX_WIDTH_DEF,
  parameter int MaxRadius = hnms_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hnms_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hnms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hnms_pkg::score_t                score_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_keypoint_o,
  output logic [hnms_pkg::COORD_W-1:0]    key_x_o,
  output logic [hnms_pkg::COORD_W-1:0]    key_y_o,
  output logic                            frame_end_o
);
  import hnms_pkg::*;

  localparam int Rows     = 2 * MaxRadius + 1;
  localparam int HistRows = 2 * MaxRadius;
  localparam int Depth    = MaxWidth + MaxRadius;
  localparam int ColW     = $clog2(Depth);
  localparam int RowW     = $clog2(MAX_HEIGHT + MaxRadius);
  localparam int RadW     = $clog2(MaxRadius + 1);

  // configuration registers
  logic [FRAME_DIM_W-1:0]  cfg_width_q, cfg_height_q;
  logic [RADIUS_CFG_W-1:0] cfg_radius_q;
  score_t                  cfg_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_FRAME_WIDTH;
      cfg_height_q <= RST_FRAME_HEIGHT;
      cfg_radius_q <= RST_WINDOW_RADIUS;
      cfg_thr_q    <= RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:     cfg_width_q  <= cfg_data_i[FRAME_DIM_W-1:0];
        CFG_FRAME_HEIGHT:    cfg_height_q <= cfg_data_i[FRAME_DIM_W-1:0];
        CFG_WINDOW_RADIUS:   cfg_radius_q <= cfg_data_i[RADIUS_CFG_W-1:0];
        CFG_SCORE_THRESHOLD: cfg_thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated geometry
  logic [ColW-1:0] sat_w;
  logic [RowW-1:0] sat_h;
  logic [RadW-1:0] sat_r;

  always_comb begin
    if (cfg_width_q == '0) begin
      sat_w = ColW'(1);
    end else if (int'(cfg_width_q) > MaxWidth) begin
      sat_w = ColW'(MaxWidth);
    end else begin
      sat_w = ColW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      sat_h = RowW'(1);
    end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
      sat_h = RowW'(MAX_HEIGHT);
    end else begin
      sat_h = RowW'(cfg_height_q);
    end
    if (int'(cfg_radius_q) > MaxRadius) begin
      sat_r = RadW'(MaxRadius);
    end else begin
      sat_r = RadW'(cfg_radius_q);
    end
  end

  // pipeline control
  logic en, accept;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // position counters and frame geometry
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] act_w_q, cur_w;
  logic [RowW-1:0] act_h_q, cur_h;
  logic [RadW-1:0] act_r_q, cur_r;
  score_t          act_thr_q, cur_thr;
  logic            first, col_end, row_end;
  logic [ColW:0]   ext_w;
  logic [RowW:0]   ext_h;

  assign first   = (col_q == '0) && (row_q == '0);
  assign cur_w   = first ? sat_w : act_w_q;
  assign cur_h   = first ? sat_h : act_h_q;
  assign cur_r   = first ? sat_r : act_r_q;
  assign cur_thr = first ? cfg_thr_q : act_thr_q;
  assign ext_w   = (ColW+1)'(cur_w) + (ColW+1)'(cur_r);
  assign ext_h   = (RowW+1)'(cur_h) + (RowW+1)'(cur_r);
  assign col_end = ((ColW+1)'(col_q) + (ColW+1)'(1)) == ext_w;
  assign row_end = ((RowW+1)'(row_q) + (RowW+1)'(1)) == ext_h;

  always_ff @(posedge clk_i) begin
    if (accept && first) begin
      act_w_q   <= sat_w;
      act_h_q   <= sat_h;
      act_r_q   <= sat_r;
      act_thr_q <= cfg_thr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // positional masks for the window of the decided pixel
  logic [Rows-1:0] row_ok, col_ok;
  logic            decided;
  logic [ColW-1:0] px;
  logic [RowW-1:0] py;

  always_comb begin
    for (int k = 0; k < Rows; k++) begin
      row_ok[k] = (k <= 2 * int'(cur_r)) && (int'(row_q) >= k) &&
                  ((int'(row_q) - k) < int'(cur_h));
      col_ok[k] = (k <= 2 * int'(cur_r)) && (int'(col_q) >= k) &&
                  ((int'(col_q) - k) < int'(cur_w));
    end
  end

  assign decided = (int'(col_q) >= int'(cur_r)) && (int'(row_q) >= int'(cur_r));
  assign px      = col_q - ColW'(cur_r);
  assign py      = row_q - RowW'(cur_r);

  // stage 1: history read
  score_t          s1_score_q;
  logic [ColW-1:0] s1_col_q;
  logic [Rows-1:0] s1_row_ok_q, s1_col_ok_q;
  logic [RadW-1:0] s1_rad_q;
  score_t          s1_thr_q;
  logic            s1_decided_q, s1_last_q;
  logic [ColW-1:0] s1_px_q;
  logic [RowW-1:0] s1_py_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_score_q   <= score_i;
      s1_col_q     <= col_q;
      s1_row_ok_q  <= row_ok;
      s1_col_ok_q  <= col_ok;
      s1_rad_q     <= cur_r;
      s1_thr_q     <= cur_thr;
      s1_decided_q <= decided;
      s1_px_q      <= px;
      s1_py_q      <= py;
      s1_last_q    <= col_end && row_end;
    end
  end

  score_t [HistRows-1:0] hist;
  score_t [Rows-1:0]     colvec;
  logic                  shift;

  assign shift = s1_valid_q && en;

  always_comb begin
    colvec[0] = s1_score_q;
    for (int k = 1; k < Rows; k++) begin
      colvec[k] = hist[k-1];
    end
  end

  hnms_line_buf #(
    .Depth (Depth),
    .Rows  (HistRows)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (hist),
    .wr_en_i   (shift),
    .wr_addr_i (s1_col_q),
    .wr_data_i (colvec[HistRows-1:0])
  );

  // stage 2: window compare
  logic [Rows-1:0] s2_row_ok_q, s2_col_ok_q;
  logic [RadW-1:0] s2_rad_q;
  score_t          s2_thr_q;
  logic            s2_decided_q, s2_last_q;
  logic [ColW-1:0] s2_px_q;
  logic [RowW-1:0] s2_py_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_row_ok_q  <= s1_row_ok_q;
      s2_col_ok_q  <= s1_col_ok_q;
      s2_rad_q     <= s1_rad_q;
      s2_thr_q     <= s1_thr_q;
      s2_decided_q <= s1_decided_q;
      s2_px_q      <= s1_px_q;
      s2_py_q      <= s1_py_q;
      s2_last_q    <= s1_last_q;
    end
  end

  score_t [Rows-1:0] win [Rows];
  logic   [Rows-1:0] gt;
  score_t            center;
  logic              keypoint;

  for (genvar j = 0; j < Rows; j++) begin : g_cell
    score_t [Rows-1:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = colvec;
    end else begin : g_link
      assign cell_in = win[j-1];
    end
    hnms_cell #(
      .Rows (Rows)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .col_i    (cell_in),
      .col_o    (win[j]),
      .col_ok_i (s2_col_ok_q[j]),
      .row_ok_i (s2_row_ok_q),
      .center_i (center),
      .gt_o     (gt[j])
    );
  end

  always_comb begin
    center = '0;
    for (int rr = 0; rr <= MaxRadius; rr++) begin
      if (int'(s2_rad_q) == rr) begin
        center = win[rr][rr];
      end
    end
  end

  assign keypoint = s2_decided_q && !(|gt) && (center > s2_thr_q);

  // stage valid flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  logic                is_kp_q, frame_end_q;
  logic [COORD_W-1:0]  key_x_q, key_y_q;

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q) begin
      is_kp_q     <= keypoint;
      key_x_q     <= s2_decided_q ? COORD_W'(s2_px_q) : '0;
      key_y_q     <= s2_decided_q ? COORD_W'(s2_py_q) : '0;
      frame_end_q <= s2_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_keypoint_o = is_kp_q;
  assign key_x_o       = key_x_q;
  assign key_y_o       = key_y_q;
  assign frame_end_o   = frame_end_q;

endmodule
